// ===== design/hks_pkg.sv =====
`default_nettype none
package hks_pkg;

   localparam int BUCKETS  = 32;
   localparam int CAPACITY = 256;

   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 64;
   localparam int STATUS_W = 2;

   // bucket count is a power of two, so the bucket is the low key bits
   localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int ENT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   // fill count and links both reach CAPACITY, which marks a chain end
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   localparam logic [CNT_W-1:0] END_MARK = CNT_W'(CAPACITY);

   typedef struct packed {
      logic load;
      logic clear;
      logic walk_first;
      logic insert;
   } hks_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              chain_empty;
      logic              hit;
      logic              chain_end;
      logic              full;
   } hks_sts_type;

   function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
      return BKT_W'(key % KEY_W'(BUCKETS));
   endfunction

endpackage
`default_nettype wire

// ===== design/hks_ram.sv =====
`default_nettype none
module hks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/hks_datapath.sv =====
`default_nettype none
module hks_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [hks_pkg::FUNC_W-1:0]  req_func,
   input  wire logic [hks_pkg::KEY_W-1:0]   req_key,
   input  wire hks_pkg::hks_cmd_type        cmd,
   output hks_pkg::hks_sts_type             sts
);
   import hks_pkg::*;

   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [BKT_W-1:0]   bkt_ff, bkt_in;
   logic [ENT_W-1:0]   head_ff, head_in;
   logic [BUCKETS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   logic [ENT_W-1:0] head_rdata;
   logic [KEY_W-1:0] key_rdata;
   logic [CNT_W-1:0] link_rdata;
   logic [ENT_W-1:0] ent_addr;
   logic [ENT_W-1:0] new_ent;
   logic [CNT_W-1:0] new_link;

   assign new_ent  = fill_ff[ENT_W-1:0];
   assign new_link = used_ff[bkt_ff] ? CNT_W'(head_ff) : END_MARK;
   // first entry comes from the bucket head, later ones follow the link
   assign ent_addr = cmd.walk_first ? head_rdata : link_rdata[ENT_W-1:0];

   always_comb begin
      func_in = func_ff;
      key_in  = key_ff;
      bkt_in  = bkt_ff;
      head_in = head_ff;
      used_in = used_ff;
      fill_in = fill_ff;
      if (cmd.load) begin
         func_in = req_func;
         key_in  = req_key;
         bkt_in  = bucket_of(req_key);
      end
      if (cmd.walk_first) begin
         head_in = head_rdata;
      end
      if (cmd.clear) begin
         used_in = '0;
         fill_in = '0;
      end else if (cmd.insert) begin
         used_in[bkt_ff] = 1'b1;
         fill_in         = fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         fill_ff <= '0;
      end else begin
         used_ff <= used_in;
         fill_ff <= fill_in;
      end
      func_ff <= func_in;
      key_ff  <= key_in;
      bkt_ff  <= bkt_in;
      head_ff <= head_in;
   end

   hks_ram #(.WIDTH(ENT_W), .DEPTH(BUCKETS)) u_head_ram (
      .clock   (clock),
      .wr_en   (cmd.insert),
      .wr_addr (bkt_ff),
      .wr_data (new_ent),
      .rd_addr (bkt_ff),
      .rd_data (head_rdata)
   );

   hks_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.insert),
      .wr_addr (new_ent),
      .wr_data (key_ff),
      .rd_addr (ent_addr),
      .rd_data (key_rdata)
   );

   hks_ram #(.WIDTH(CNT_W), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.insert),
      .wr_addr (new_ent),
      .wr_data (new_link),
      .rd_addr (ent_addr),
      .rd_data (link_rdata)
   );

   always_comb begin
      sts.func        = func_ff;
      sts.chain_empty = !used_ff[bkt_ff] || (CNT_W'(head_rdata) >= fill_ff);
      sts.hit         = (key_rdata == key_ff);
      // link at or past the fill count covers the end mark too
      sts.chain_end   = (link_rdata >= fill_ff);
      sts.full        = (fill_ff == END_MARK);
   end

endmodule
`default_nettype wire

// ===== design/hks_ctrl.sv =====
`default_nettype none
module hks_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [hks_pkg::FUNC_W-1:0]    req_func,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_found,
   output logic      [hks_pkg::STATUS_W-1:0]  rsp_status,
   output hks_pkg::hks_cmd_type               cmd,
   input  wire hks_pkg::hks_sts_type          sts
);
   import hks_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_FIRST,
      S_CHECK,
      S_INSERT,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic                found_ff, found_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic accept;
   logic hit_ev;
   logic miss_ev;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      cmd           = '0;
      hit_ev        = 1'b0;
      miss_ev       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load  = 1'b1;
               found_in  = 1'b0;
               status_in = STATUS_OK;
               case (req_func)
                  FUNC_QUERY:  state_in = S_HEAD;
                  FUNC_INSERT: state_in = S_HEAD;
                  FUNC_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = S_DONE;
                  end
                  default:     state_in = S_DONE;
               endcase
            end
         end
         // head memory read in flight
         S_HEAD: state_in = S_FIRST;
         S_FIRST: begin
            cmd.walk_first = 1'b1;
            if (sts.chain_empty) begin
               miss_ev = 1'b1;
            end else begin
               state_in = S_CHECK;
            end
         end
         // one chain entry per cycle, next entry read issued from the link
         S_CHECK: begin
            if (sts.hit) begin
               hit_ev = 1'b1;
            end else if (sts.chain_end) begin
               miss_ev = 1'b1;
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (hit_ev) begin
         found_in  = 1'b1;
         status_in = (sts.func == FUNC_INSERT) ? STATUS_DUP : STATUS_OK;
         state_in  = S_DONE;
      end else if (miss_ev) begin
         found_in = 1'b0;
         if (sts.func != FUNC_INSERT) begin
            status_in = STATUS_OK;
            state_in  = S_DONE;
         end else if (sts.full) begin
            status_in = STATUS_FULL;
            state_in  = S_DONE;
         end else begin
            status_in = STATUS_OK;
            state_in  = S_INSERT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;

endmodule
`default_nettype wire

// ===== design/hashed_key_set_top.sv =====
// sequence: a query or insert runs S_HEAD, S_FIRST, then S_CHECK over the chain entries
// visited (one a cycle), then S_DONE; a new key adds S_INSERT; clear goes straight to S_DONE
// throughput: one word in flight; the chain walk through the entry memories sets the rate,
// so the next word is taken once the previous result sits in the output register
// reset: synchronous, clears the bucket valid bits, the fill count and the handshakes;
// the bucket head and entry memories are not cleared and need no clearing pass
`default_nettype none
module hashed_key_set_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [hks_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [hks_pkg::KEY_W-1:0]     req_key,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_found,
   output logic      [hks_pkg::STATUS_W-1:0]  rsp_status
);
   import hks_pkg::*;

   hks_cmd_type cmd;
   hks_sts_type sts;

   hks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_found  (rsp_found),
      .rsp_status (rsp_status),
      .cmd        (cmd),
      .sts        (sts)
   );

   hks_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_func (req_func),
      .req_key  (req_key),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import hks_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam logic [KEY_W-1:0]  KEY_TOP    = '1;

   typedef struct packed {
      logic                found;
      logic [STATUS_W-1:0] status;
   } verdict_type;

   localparam verdict_type V_MISS = '{found: 1'b0, status: STATUS_OK};
   localparam verdict_type V_DUP  = '{found: 1'b1, status: STATUS_DUP};

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key;
      bit                typed;
      verdict_type       want;
   } drill_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [FUNC_W-1:0]   req_func;
   logic [KEY_W-1:0]    req_key;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_found;
   logic [STATUS_W-1:0] rsp_status;

   hashed_key_set_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_found  (rsp_found),
      .rsp_status (rsp_status)
   );

   // shadow copy of the hash set
   logic [ENT_W-1:0] head_of    [BUCKETS];
   bit               chain_live [BUCKETS];
   logic [KEY_W-1:0] slot_key   [CAPACITY];
   logic [CNT_W-1:0] slot_next  [CAPACITY];
   logic [CNT_W-1:0] slots_used = '0;

   verdict_type      pending_verdicts[$];
   logic [KEY_W-1:0] kept_keys[$];
   logic [KEY_W-1:0] key_pool[24];

   int unsigned mismatches = 0;
   int unsigned n_query = 0, n_insert = 0, n_clear = 0, n_spare = 0;
   int unsigned n_hit = 0, n_dup = 0, n_full = 0, deepest_walk = 0;
   bit          calm = 1'b0;
   bit          stall_request = 1'b0;

   // nonzero rows carry the typed result, the rest follow the shadow set
   drill_row_type drill [22] = '{
      '{FUNC_QUERY,  64'h0,                  1'b1, V_MISS},
      '{FUNC_QUERY,  KEY_TOP,                1'b1, V_MISS},
      '{FUNC_INSERT, 64'h0,                  1'b1, V_MISS},
      '{FUNC_INSERT, 64'h0,                  1'b1, V_DUP},
      '{FUNC_INSERT, KEY_TOP,                1'b1, V_MISS},
      '{FUNC_QUERY,  KEY_TOP,                1'b0, V_MISS},
      '{FUNC_INSERT, 64'h20,                 1'b0, V_MISS},
      '{FUNC_INSERT, 64'h8000_0000_0000_0000, 1'b0, V_MISS},
      '{FUNC_QUERY,  64'h20,                 1'b0, V_MISS},
      '{FUNC_QUERY,  64'h0,                  1'b0, V_MISS},
      '{FUNC_QUERY,  64'h40,                 1'b0, V_MISS},
      '{FUNC_INSERT, 64'h5555_5555_5555_5555, 1'b0, V_MISS},
      '{FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, V_MISS},
      '{FUNC_SPARE,  KEY_TOP,                1'b1, V_MISS},
      '{FUNC_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, V_MISS},
      '{FUNC_CLEAR,  64'h5555_5555_5555_5555, 1'b1, V_MISS},
      '{FUNC_QUERY,  64'h0,                  1'b1, V_MISS},
      '{FUNC_QUERY,  KEY_TOP,                1'b1, V_MISS},
      '{FUNC_INSERT, 64'h20,                 1'b1, V_MISS},
      '{FUNC_QUERY,  64'h20,                 1'b0, V_MISS},
      '{FUNC_INSERT, 64'h1F,                 1'b0, V_MISS},
      '{FUNC_CLEAR,  KEY_TOP,                1'b1, V_MISS}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #3_000_000;
      $display("timeout with %0d results outstanding", pending_verdicts.size());
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   function automatic bit set_holds(logic [KEY_W-1:0] k);
      logic [BKT_W-1:0] b;
      logic [CNT_W-1:0] e;
      int unsigned      hops;
      b = BKT_W'(k % BUCKETS);
      if (!chain_live[b]) return 1'b0;
      e = CNT_W'(head_of[b]);
      hops = 0;
      while (e < END_MARK && e < slots_used && hops < CAPACITY) begin
         hops++;
         if (hops > deepest_walk) deepest_walk = hops;
         if (slot_key[e[ENT_W-1:0]] == k) return 1'b1;
         e = slot_next[e[ENT_W-1:0]];
      end
      return 1'b0;
   endfunction

   function automatic verdict_type key_set_apply(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k);
      verdict_type      v;
      logic [BKT_W-1:0] b;
      v = V_MISS;
      b = BKT_W'(k % BUCKETS);
      case (f)
         FUNC_QUERY: begin
            v.found = set_holds(k);
         end
         FUNC_INSERT: begin
            if (set_holds(k)) begin
               v = V_DUP;
            end else if (slots_used >= END_MARK) begin
               v.status = STATUS_FULL;
            end else begin
               slot_key[slots_used[ENT_W-1:0]]  = k;
               slot_next[slots_used[ENT_W-1:0]] = chain_live[b] ? CNT_W'(head_of[b]) : END_MARK;
               head_of[b]                       = slots_used[ENT_W-1:0];
               chain_live[b]                    = 1'b1;
               slots_used++;
            end
         end
         FUNC_CLEAR: begin
            chain_live = '{default: 1'b0};
            slots_used = '0;
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_word(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                            input bit typed, input verdict_type typed_v);
      int unsigned gap;
      verdict_type v;
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_key   <= k;
      do @(posedge clock); while (!req_ready);
      v = key_set_apply(f, k);
      case (f)
         FUNC_QUERY:  begin n_query++;  if (v.found) n_hit++; end
         FUNC_INSERT: begin
            n_insert++;
            if (v.status == STATUS_DUP) n_dup++;
            if (v.status == STATUS_FULL) n_full++;
         end
         FUNC_CLEAR:  n_clear++;
         default:     n_spare++;
      endcase
      pending_verdicts.push_back(typed ? typed_v : v);
   endtask

   // mixed traffic over a small pool of keys, two in three crowded into buckets zero to three
   task automatic pool_traffic(input int unsigned count, input int unsigned hold_at);
      int unsigned      r;
      logic [FUNC_W-1:0] f;
      logic [KEY_W-1:0]  k;
      for (int unsigned i = 0; i < count; i++) begin
         if (i == hold_at) stall_request = 1'b1;
         r = $urandom_range(0, 99);
         k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 23)] : rand_key();
         if (r < 45) f = FUNC_INSERT;
         else if (r < 91) f = FUNC_QUERY;
         else if (r < 94) f = FUNC_CLEAR;
         else if (r < 97) f = FUNC_SPARE;
         else begin
            f = FUNC_QUERY;
            k = rand_key();
         end
         send_word(f, k, 1'b0, V_MISS);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                  input logic [KEY_W-1:0] want);
      $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("word with nothing pending, found", KEY_W'(rsp_found), '0);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_found !== want.found) begin
               report_mismatch("found", KEY_W'(rsp_found), KEY_W'(want.found));
            end
            if (rsp_status !== want.status) begin
               report_mismatch("status", KEY_W'(rsp_status), KEY_W'(want.status));
            end
         end
      end
   end

   // receiver: random ready bursts, one long hold-off on request, steady at the end
   initial begin
      int unsigned n;
      rsp_ready <= 1'b0;
      forever begin
         if (stall_request) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            stall_request = 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            n = $urandom_range(1, 14);
            rsp_ready <= ($urandom_range(0, 2) != 0);
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin
      logic [KEY_W-1:0] k;
      req_valid <= 1'b0;
      req_func  <= FUNC_QUERY;
      req_key   <= '0;
      for (int i = 0; i < 24; i++) begin
         key_pool[i] = rand_key();
         if (i % 3 != 2) key_pool[i][BKT_W-1:0] = BKT_W'($urandom_range(0, 3));
      end
      @(posedge clock);
      while (reset) @(posedge clock);

      foreach (drill[i]) send_word(drill[i].func, drill[i].key, drill[i].typed, drill[i].want);

      pool_traffic(180, 60);

      // fill the store, half the keys piled onto bucket zero
      send_word(FUNC_CLEAR, rand_key(), 1'b0, V_MISS);
      while (slots_used < END_MARK) begin
         k = rand_key();
         if ($urandom_range(0, 1) == 1) k[BKT_W-1:0] = '0;
         kept_keys.push_back(k);
         send_word(FUNC_INSERT, k, 1'b0, V_MISS);
      end
      for (int i = 0; i < 24; i++) begin
         case (i % 3)
            0:       send_word(FUNC_INSERT, rand_key(), 1'b0, V_MISS);
            1:       send_word(FUNC_INSERT, kept_keys[$urandom_range(0, kept_keys.size() - 1)],
                               1'b0, V_MISS);
            default: send_word(FUNC_QUERY, kept_keys[$urandom_range(0, kept_keys.size() - 1)],
                               1'b0, V_MISS);
         endcase
      end
      send_word(FUNC_CLEAR, rand_key(), 1'b0, V_MISS);

      calm = 1'b1;
      pool_traffic(60, 1000);
      req_valid <= 1'b0;

      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d queries (%0d hits), %0d inserts, %0d clears, %0d spare codes",
               n_query, n_hit, n_insert, n_clear, n_spare);
      $display("inserts refused: %0d duplicate, %0d full; longest chain walk %0d entries",
               n_dup, n_full, deepest_walk);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/hks_pkg.sv
design/hks_ram.sv
design/hks_datapath.sv
design/hks_ctrl.sv
design/hashed_key_set_top.sv
tb/sv/tb_top.sv
